// ----- sv/rpa_pkg.sv -----
// Package for the ring pair axial orientation check.
// Shared types, sum width and saturation limits, axis codes and queue depths.
// No dependencies.
package rpa_pkg;

    // Width of one plane accumulator and its saturation limits
    localparam int SUM_BITS = 56;
    typedef logic signed [SUM_BITS-1:0] t_sum;
    localparam t_sum SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    // Axial dimension codes; the fourth code means no ring is axial
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIAL_DIM_RESET = AXIS_Z;

    // Plane index of each accumulator
    localparam int PLANE_XY = 0;
    localparam int PLANE_XZ = 1;
    localparam int PLANE_YZ = 2;

    // Queue depths between front and back, and for results
    localparam int JOB_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 4;

    // Control flags of one job handed from front to back
    typedef struct packed {
        logic clr;     // first vertex of a ring: start sums from zero
        logic last;    // last vertex: ring closes, a result follows
        logic second;  // ring tag taken at the ring's first vertex
        logic over;    // ring has more vertices than allowed
    } t_job_ctl;

    // One result transaction
    typedef struct packed {
        logic ring_axial;
        logic pair_done;
        logic pair_axial;
    } t_result;

endpackage

// ----- sv/rpa_fifo.sv -----
// Small register-based queue with full/empty flags.
// Used between front and back and for results. Depends on nothing.
module rpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("queue occupancy above depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !i_pop) |=> !o_empty)
        else $error("queue empty after a push");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_pop && !i_push && r_count == CNTW'(1)) |=> o_empty)
        else $error("queue not empty after popping its only entry");

endmodule

// ----- sv/rpa_front.sv -----
// Front end: tracks the open ring and turns each vertex into a job.
// Forms sum/difference operands for the edge from the prior vertex and the
// closing edge back to the first vertex. Depends on rpa_pkg.
module rpa_front #(
    parameter int COORD_BITS = 24,
    parameter int MAX_RING_VERTICES = 16,
    localparam int OW = COORD_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_z,
    input  logic                         i_from_second_ring,
    input  logic                         i_last_vertex,
    output rpa_pkg::t_job_ctl            o_ctl,
    output logic [8*OW-1:0]              o_ops
);

    localparam int CNTW = $clog2(MAX_RING_VERTICES + 2);
    localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_RING_VERTICES);

    logic signed [COORD_BITS-1:0] r_start [3];
    logic signed [COORD_BITS-1:0] r_prior [3];
    logic                         r_open;
    logic                         r_tag;
    logic [CNTW-1:0]              r_count, n_count;

    logic signed [OW-1:0] w_c [3];
    logic signed [OW-1:0] w_p [3];
    logic signed [OW-1:0] w_s [3];
    logic signed [OW-1:0] e0_sx, e0_sy, e0_dy, e0_dz;
    logic signed [OW-1:0] e1_sx, e1_sy, e1_dy, e1_dz;

    // Widen coordinates by one bit for sums and differences
    always_comb begin
        w_c[0] = OW'(i_vertex_x);
        w_c[1] = OW'(i_vertex_y);
        w_c[2] = OW'(i_vertex_z);
        for (int k = 0; k < 3; k++) begin
            w_p[k] = OW'(r_prior[k]);
            w_s[k] = OW'(r_start[k]);
        end
    end

    // Edge from prior vertex to this one; zero on a ring's first vertex
    always_comb begin
        e0_sx = '0;
        e0_sy = '0;
        e0_dy = '0;
        e0_dz = '0;
        if (r_open) begin
            e0_sx = w_p[0] + w_c[0];
            e0_sy = w_p[1] + w_c[1];
            e0_dy = w_p[1] - w_c[1];
            e0_dz = w_p[2] - w_c[2];
        end
    end

    // Closing edge back to the first vertex; a one-vertex ring adds nothing
    always_comb begin
        e1_sx = '0;
        e1_sy = '0;
        e1_dy = '0;
        e1_dz = '0;
        if (r_open && i_last_vertex) begin
            e1_sx = w_c[0] + w_s[0];
            e1_sy = w_c[1] + w_s[1];
            e1_dy = w_c[1] - w_s[1];
            e1_dz = w_c[2] - w_s[2];
        end
    end

    // Vertex count saturates one past the limit
    always_comb begin
        if (!r_open) begin
            n_count = CNTW'(1);
        end else if (r_count <= MAXC) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    assign o_ops = {e1_dz, e1_dy, e1_sy, e1_sx, e0_dz, e0_dy, e0_sy, e0_sx};

    always_comb begin
        o_ctl.clr    = !r_open;
        o_ctl.last   = i_last_vertex;
        o_ctl.second = r_open ? r_tag : i_from_second_ring;
        o_ctl.over   = (n_count > MAXC);
    end

    // Ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_tag   <= 1'b0;
            r_count <= '0;
        end else if (i_accept) begin
            r_open  <= !i_last_vertex;
            r_count <= n_count;
            if (!r_open) begin
                r_tag <= i_from_second_ring;
            end
        end
    end

    // Vertex storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prior[0] <= i_vertex_x;
            r_prior[1] <= i_vertex_y;
            r_prior[2] <= i_vertex_z;
            if (!r_open) begin
                r_start[0] <= i_vertex_x;
                r_start[1] <= i_vertex_y;
                r_start[2] <= i_vertex_z;
            end
        end
    end

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_vertex) |=> !r_open)
        else $error("ring still open after its last vertex");

    a_vertex_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_vertex) |=> r_open)
        else $error("ring not open after a non-final vertex");

    a_tag_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !r_open) |=> (r_tag == $past(i_from_second_ring)))
        else $error("ring tag not taken from the first vertex");

endmodule

// ----- sv/rpa_back.sv -----
// Back end: multiplies the edge operands, accumulates saturated shoelace
// sums per plane and decides the ring and pair verdicts at ring close.
// Depends on rpa_pkg.
module rpa_back #(
    parameter int COORD_BITS = 24,
    localparam int OW = COORD_BITS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_axial_dim,
    input  logic              i_job_empty,
    input  rpa_pkg::t_job_ctl i_job_ctl,
    input  logic [8*OW-1:0]   i_job_ops,
    output logic              o_job_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output rpa_pkg::t_result  o_res
);

    localparam int SB = rpa_pkg::SUM_BITS;
    localparam int PW = 2 * OW;
    localparam int EW = (PW > SB) ? PW : SB;
    localparam logic signed [EW-1:0] MAXW = EW'(rpa_pkg::SUM_MAX);
    localparam logic signed [EW-1:0] MINW = EW'(rpa_pkg::SUM_MIN);

    // Clamp one edge product to the accumulator range
    function automatic rpa_pkg::t_sum sat_term(input logic signed [PW-1:0] v);
        logic signed [EW-1:0] w;
        w = EW'(v);
        if (w > MAXW) begin
            return rpa_pkg::SUM_MAX;
        end else if (w < MINW) begin
            return rpa_pkg::SUM_MIN;
        end
        return w[SB-1:0];
    endfunction

    // Saturating add of two accumulator-width values
    function automatic rpa_pkg::t_sum sat_add(input rpa_pkg::t_sum a,
                                              input rpa_pkg::t_sum b);
        logic [SB:0] s;
        s = {a[SB-1], a} + {b[SB-1], b};
        if (s[SB] != s[SB-1]) begin
            return s[SB] ? rpa_pkg::SUM_MIN : rpa_pkg::SUM_MAX;
        end
        return s[SB-1:0];
    endfunction

    logic                 w_adv;
    logic signed [OW-1:0] w_op [8];
    logic signed [PW-1:0] w_prod [6];

    logic                 r_s1_valid;
    rpa_pkg::t_job_ctl    r_s1_ctl;
    logic signed [PW-1:0] r_prod [6];

    logic                 r_s2_valid;
    rpa_pkg::t_job_ctl    r_s2_ctl;
    rpa_pkg::t_sum        r_sum [3];
    rpa_pkg::t_sum        n_sum [3];

    logic [SB-1:0]        w_mag [3];
    logic                 w_axial;
    logic                 r_verdict;

    // Whole pipeline holds only when a closing ring finds no result room
    assign w_adv     = !(r_s2_valid && r_s2_ctl.last && i_res_full);
    assign o_job_pop = w_adv && !i_job_empty;

    // Stage 1: three products per edge
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_op[k] = $signed(i_job_ops[k*OW +: OW]);
        end
        for (int e = 0; e < 2; e++) begin
            w_prod[3*e + rpa_pkg::PLANE_XY] = PW'(w_op[4*e]) * PW'(w_op[4*e + 2]);
            w_prod[3*e + rpa_pkg::PLANE_XZ] = PW'(w_op[4*e]) * PW'(w_op[4*e + 3]);
            w_prod[3*e + rpa_pkg::PLANE_YZ] = PW'(w_op[4*e + 1]) * PW'(w_op[4*e + 3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= o_job_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1_ctl <= i_job_ctl;
            r_prod   <= w_prod;
        end
    end

    // Stage 2: prior edge then closing edge into each plane sum
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            n_sum[m] = sat_add(r_s1_ctl.clr ? '0 : r_sum[m], sat_term(r_prod[m]));
            n_sum[m] = sat_add(n_sum[m], sat_term(r_prod[3 + m]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_s2_ctl <= r_s1_ctl;
            r_sum    <= n_sum;
        end
    end

    // Verdict on the closed ring from the final sums
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            w_mag[m] = r_sum[m][SB-1] ? (~r_sum[m] + 1'b1) : r_sum[m];
        end
        case (i_axial_dim)
            rpa_pkg::AXIS_X: w_axial = (w_mag[rpa_pkg::PLANE_YZ] > w_mag[rpa_pkg::PLANE_XY])
                                    && (w_mag[rpa_pkg::PLANE_YZ] > w_mag[rpa_pkg::PLANE_XZ]);
            rpa_pkg::AXIS_Y: w_axial = (w_mag[rpa_pkg::PLANE_XZ] > w_mag[rpa_pkg::PLANE_XY])
                                    && (w_mag[rpa_pkg::PLANE_XZ] > w_mag[rpa_pkg::PLANE_YZ]);
            rpa_pkg::AXIS_Z: w_axial = (w_mag[rpa_pkg::PLANE_XY] > w_mag[rpa_pkg::PLANE_XZ])
                                    && (w_mag[rpa_pkg::PLANE_XY] > w_mag[rpa_pkg::PLANE_YZ]);
            default:         w_axial = 1'b0;
        endcase
        if (r_s2_ctl.over) begin
            w_axial = 1'b0;
        end
    end

    // Result transaction
    assign o_res_push       = r_s2_valid && r_s2_ctl.last && !i_res_full;
    assign o_res.ring_axial = w_axial;
    assign o_res.pair_done  = r_s2_ctl.second;
    assign o_res.pair_axial = r_s2_ctl.second && w_axial && r_verdict;

    // First ring verdict kept for pairing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict <= 1'b0;
        end else if (o_res_push && !r_s2_ctl.second) begin
            r_verdict <= w_axial;
        end
    end

    a_sums_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_adv) |=> ($stable(r_sum[0]) && $stable(r_sum[1])
                                    && $stable(r_sum[2])))
        else $error("plane sums changed while stalled");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> r_s1_valid)
        else $error("product stage dropped a job while stalled");

    a_verdict_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && !r_s2_ctl.second) |=> (r_verdict == $past(w_axial)))
        else $error("first ring verdict not stored");

endmodule

// ----- sv/ring_pair_axial_orientation_check_core.sv -----
// Ring pair axial orientation check, top level.
// Depends on rpa_pkg, rpa_fifo, rpa_front and rpa_back.
// Usage:
//   Vertices enter through a queue-style port: a transaction is taken at a
//   clock edge with i_push high and o_full low. Each vertex carries its ring
//   tag and a last-vertex mark. Results leave through a queue-style port:
//   while o_empty is low the oldest result is on o_ring_axial, o_pair_done
//   and o_pair_axial, and i_pop high at a clock edge takes it. One result
//   follows each last vertex; other vertices give none. The axial dimension
//   register is written with i_cfg_we / i_cfg_data while the block is idle.
// Timing:
//   One vertex per cycle while o_full is low. After its last vertex is taken,
//   a result passes the job queue, product stage and accumulate stage, then
//   the result queue, before it is visible.
// Reset:
//   Synchronous, active low. Clears the open ring, the stored first ring
//   verdict and both queues; the axial dimension returns to z.
// Stalls:
//   A 4-entry result queue absorbs results while the receiver does not pop.
//   When it fills, the back end holds and the 2-entry job queue raises o_full.
module ring_pair_axial_orientation_check_core #(
    parameter int COORD_BITS = 24,
    parameter int MAX_RING_VERTICES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_z,
    input  logic                         i_from_second_ring,
    input  logic                         i_last_vertex,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic                         o_ring_axial,
    output logic                         o_pair_done,
    output logic                         o_pair_axial,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_data
);

    localparam int OW   = COORD_BITS + 1;
    localparam int CTLW = $bits(rpa_pkg::t_job_ctl);
    localparam int JOBW = CTLW + 8 * OW;
    localparam int RESW = $bits(rpa_pkg::t_result);

    logic [1:0]        r_axial_dim;
    logic              w_accept;
    rpa_pkg::t_job_ctl w_front_ctl;
    logic [8*OW-1:0]   w_front_ops;
    logic [JOBW-1:0]   w_job_data;
    logic              w_job_empty;
    logic              w_job_pop;
    logic              w_res_full;
    logic              w_res_push;
    rpa_pkg::t_result  w_res;
    rpa_pkg::t_result  w_res_out;
    logic [RESW-1:0]   w_res_data;

    // Axial dimension register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axial_dim <= rpa_pkg::AXIAL_DIM_RESET;
        end else if (i_cfg_we) begin
            r_axial_dim <= i_cfg_data;
        end
    end

    assign w_accept = i_push && !o_full;

    rpa_front #(
        .COORD_BITS        (COORD_BITS),
        .MAX_RING_VERTICES (MAX_RING_VERTICES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_vertex_x         (i_vertex_x),
        .i_vertex_y         (i_vertex_y),
        .i_vertex_z         (i_vertex_z),
        .i_from_second_ring (i_from_second_ring),
        .i_last_vertex      (i_last_vertex),
        .o_ctl              (w_front_ctl),
        .o_ops              (w_front_ops)
    );

    // Job queue between front and back
    rpa_fifo #(
        .WIDTH (JOBW),
        .DEPTH (rpa_pkg::JOB_QUEUE_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  ({w_front_ctl, w_front_ops}),
        .i_pop   (w_job_pop),
        .o_data  (w_job_data),
        .o_full  (o_full),
        .o_empty (w_job_empty)
    );

    rpa_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_axial_dim (r_axial_dim),
        .i_job_empty (w_job_empty),
        .i_job_ctl   (rpa_pkg::t_job_ctl'(w_job_data[JOBW-1 -: CTLW])),
        .i_job_ops   (w_job_data[8*OW-1:0]),
        .o_job_pop   (w_job_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Result queue toward the receiver
    rpa_fifo #(
        .WIDTH (RESW),
        .DEPTH (rpa_pkg::RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (i_pop),
        .o_data  (w_res_data),
        .o_full  (w_res_full),
        .o_empty (o_empty)
    );

    assign w_res_out    = rpa_pkg::t_result'(w_res_data);
    assign o_ring_axial = w_res_out.ring_axial;
    assign o_pair_done  = w_res_out.pair_done;
    assign o_pair_axial = w_res_out.pair_axial;

endmodule

// ----- test/tb_ring_pair_axial_orientation_check_core.sv -----
// Testbench for ring_pair_axial_orientation_check_core: directed and random rings
// checked against a shoelace-area predictor. Depends on rpa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_ring_pair_axial_orientation_check_core;

    localparam int COORD_W = 24;
    localparam int MAX_VERTS = 16;
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [1:0] AXIS_NONE = 2'd3;   // invalid code: nothing is axial
    localparam longint AREA_MAX = longint'(rpa_pkg::SUM_MAX);
    localparam longint AREA_MIN = longint'(rpa_pkg::SUM_MIN);
    localparam int RANDOM_ITEMS = 900;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTS = 40;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_push = 1'b0;
    logic                      o_full;
    logic signed [COORD_W-1:0] i_vertex_x = '0;
    logic signed [COORD_W-1:0] i_vertex_y = '0;
    logic signed [COORD_W-1:0] i_vertex_z = '0;
    logic                      i_from_second_ring = 1'b0;
    logic                      i_last_vertex = 1'b0;
    logic                      o_empty;
    logic                      i_pop = 1'b0;
    logic                      o_ring_axial;
    logic                      o_pair_done;
    logic                      o_pair_axial;
    logic                      i_cfg_we = 1'b0;
    logic [1:0]                i_cfg_data = rpa_pkg::AXIAL_DIM_RESET;

    // Predictor state
    logic [1:0] axis_sel = rpa_pkg::AXIAL_DIM_RESET;
    longint     ring_start [3];
    longint     ring_prev [3];
    longint     area2 [3] = '{0, 0, 0};   // doubled signed areas XY, XZ, YZ
    bit         open_ring = 1'b0;
    bit         open_is_second = 1'b0;
    bit         verdict_first = 1'b0;
    int         open_count = 0;

    rpa_pkg::t_result pending_verdicts [$];
    int         errors = 0;
    int         items_sent = 0;
    int         stall_cycles = 0;
    bit         idle_en = 1'b1;
    int         pop_hold = 0;

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ring_pair_axial_orientation_check_core #(
        .COORD_BITS        (COORD_W),
        .MAX_RING_VERTICES (MAX_VERTS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_vertex_x         (i_vertex_x),
        .i_vertex_y         (i_vertex_y),
        .i_vertex_z         (i_vertex_z),
        .i_from_second_ring (i_from_second_ring),
        .i_last_vertex      (i_last_vertex),
        .o_empty            (o_empty),
        .i_pop              (i_pop),
        .o_ring_axial       (o_ring_axial),
        .o_pair_done        (o_pair_done),
        .o_pair_axial       (o_pair_axial),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data)
    );

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // ---------------- predictor ----------------
    function automatic longint clamp_area(input longint s);
        if (s > AREA_MAX) return AREA_MAX;
        if (s < AREA_MIN) return AREA_MIN;
        return s;
    endfunction

    function automatic longint abs_area(input longint s);
        return (s < 0) ? -s : s;
    endfunction

    // One shoelace edge from vertex j (earlier) to vertex i (later)
    function automatic void add_edge(input longint jx, jy, jz, ix, iy, iz);
        area2[rpa_pkg::PLANE_XY] =
            clamp_area(area2[rpa_pkg::PLANE_XY] + (jx + ix) * (jy - iy));
        area2[rpa_pkg::PLANE_XZ] =
            clamp_area(area2[rpa_pkg::PLANE_XZ] + (jx + ix) * (jz - iz));
        area2[rpa_pkg::PLANE_YZ] =
            clamp_area(area2[rpa_pkg::PLANE_YZ] + (jy + iy) * (jz - iz));
    endfunction

    function automatic void shoelace_step(input logic signed [COORD_W-1:0] x, y, z,
                                          input logic second, last);
        longint           c [3];
        longint           xy, xz, yz;
        bit               axial;
        rpa_pkg::t_result r;
        c[0] = longint'(x);
        c[1] = longint'(y);
        c[2] = longint'(z);
        if (!open_ring) begin
            ring_start = c;
            area2 = '{0, 0, 0};
            open_is_second = second;
            open_count = 1;
            open_ring = 1'b1;
        end else begin
            add_edge(ring_prev[0], ring_prev[1], ring_prev[2], c[0], c[1], c[2]);
            if (open_count <= MAX_VERTS) open_count++;
        end
        ring_prev = c;
        if (last) begin
            add_edge(c[0], c[1], c[2], ring_start[0], ring_start[1], ring_start[2]);
            xy = abs_area(area2[rpa_pkg::PLANE_XY]);
            xz = abs_area(area2[rpa_pkg::PLANE_XZ]);
            yz = abs_area(area2[rpa_pkg::PLANE_YZ]);
            case (axis_sel)
                rpa_pkg::AXIS_X: axial = (yz > xy) && (yz > xz);
                rpa_pkg::AXIS_Y: axial = (xz > xy) && (xz > yz);
                rpa_pkg::AXIS_Z: axial = (xy > xz) && (xy > yz);
                default: axial = 1'b0;
            endcase
            if (open_count > MAX_VERTS) axial = 1'b0;
            open_ring = 1'b0;
            r.ring_axial = axial;
            if (open_is_second) begin
                r.pair_done = 1'b1;
                r.pair_axial = axial && verdict_first;
            end else begin
                verdict_first = axial;
                r.pair_done = 1'b0;
                r.pair_axial = 1'b0;
            end
            pending_verdicts = {pending_verdicts, r};
        end
    endfunction

    // ---------------- result side ----------------
    task automatic check_result();
        rpa_pkg::t_result e;
        if (pending_verdicts.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
        end else begin
            e = pending_verdicts.pop_front();
            if (o_ring_axial !== e.ring_axial)
                report_mismatch($sformatf("ring_axial %b, expected %b",
                                          o_ring_axial, e.ring_axial));
            if (o_pair_done !== e.pair_done)
                report_mismatch($sformatf("pair_done %b, expected %b",
                                          o_pair_done, e.pair_done));
            if (o_pair_axial !== e.pair_axial)
                report_mismatch($sformatf("pair_axial %b, expected %b",
                                          o_pair_axial, e.pair_axial));
        end
    endtask

    // Check accepted results, then pick pop for the next edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
            pop_hold = 0;
        end else begin
            if (i_pop && !o_empty) check_result();
            if (pop_hold > 0) begin
                pop_hold--;
                i_pop <= 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                pop_hold = $urandom_range(0, 13);
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // ---------------- input side ----------------
    task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, z,
                               input logic second, last);
        if (idle_en && $urandom_range(0, 9) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_vertex_x <= x;
        i_vertex_y <= y;
        i_vertex_z <= z;
        i_from_second_ring <= second;
        i_last_vertex <= last;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        shoelace_step(x, y, z, second, last);
        items_sent++;
    endtask

    // Stop pushing and let every expected result come out
    task automatic wait_drained();
        i_push <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_axial_dim(input logic [1:0] axis);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= axis;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        axis_sel = axis;
    endtask

    function automatic logic signed [COORD_W-1:0] to_coord(input real v);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return COORD_W'($rtoi(v));
    endfunction

    // Polygon of n vertices around a circle in the plane normal to 'normal',
    // with optional tilt out of that plane and optional noisy tags on later vertices
    task automatic send_planar_ring(input int n, input logic [1:0] normal,
                                    input logic tag, input int scale_bits,
                                    input real tilt, input bit messy_tags);
        real  r, cu, cv, cw, tu, tv, ang, du, dv, w, dir;
        int   lim;
        logic signed [COORD_W-1:0] pu, pv, pw;
        logic sec;
        r = $urandom_range(1, 1 << scale_bits);
        lim = COORD_MAX - 2 * $rtoi(r);
        if (lim < 1) lim = 1;
        cu = $itor($urandom_range(0, 2 * lim)) - lim;
        cv = $itor($urandom_range(0, 2 * lim)) - lim;
        cw = $itor($urandom_range(0, 2 * lim)) - lim;
        tu = tilt * ($urandom_range(0, 1000) / 500.0 - 1.0);
        tv = tilt * ($urandom_range(0, 1000) / 500.0 - 1.0);
        dir = $urandom_range(0, 1) ? 1.0 : -1.0;
        for (int k = 0; k < n; k++) begin
            ang = dir * 6.2831853 * k / n
                + ($urandom_range(0, 1000) / 1000.0 - 0.5) * 0.4 / n;
            du = r * $cos(ang);
            dv = r * $sin(ang);
            w = cw + tu * du + tv * dv + ($urandom_range(0, 1000) / 1000.0 - 0.5) * r / 8;
            pu = to_coord(cu + du);
            pv = to_coord(cv + dv);
            pw = to_coord(w);
            sec = (k == 0 || !messy_tags) ? tag : 1'($urandom_range(0, 1));
            case (normal)
                rpa_pkg::AXIS_X: send_vertex(pw, pu, pv, sec, k == n - 1);
                rpa_pkg::AXIS_Y: send_vertex(pu, pw, pv, sec, k == n - 1);
                default: send_vertex(pu, pv, pw, sec, k == n - 1);
            endcase
        end
    endtask

    // Square of full-scale side walked fwd times one way, then rev times back
    task automatic send_square_loops(input int fwd, input int rev, input logic tag);
        logic signed [COORD_W-1:0] m;
        int total, idx;
        m = COORD_MAX;
        total = 4 * (fwd + rev);
        idx = 0;
        for (int l = 0; l < fwd; l++) begin
            send_vertex(-m, -m, 0, tag, ++idx == total);
            send_vertex( m, -m, 0, tag, ++idx == total);
            send_vertex( m,  m, 0, tag, ++idx == total);
            send_vertex(-m,  m, 0, tag, ++idx == total);
        end
        for (int l = 0; l < rev; l++) begin
            send_vertex(-m, -m, 0, tag, ++idx == total);
            send_vertex(-m,  m, 0, tag, ++idx == total);
            send_vertex( m,  m, 0, tag, ++idx == total);
            send_vertex( m, -m, 0, tag, ++idx == total);
        end
    endtask

    // ---------------- tests ----------------
    // Second ring right after reset pairs with the reset verdict
    task automatic test_second_before_first();
        send_vertex(0, 0, 0, 1'b1, 1'b0);
        send_vertex(1000, 0, 0, 1'b1, 1'b0);
        send_vertex(0, 1000, 5, 1'b1, 1'b1);
    endtask

    // One and two vertex rings have zero area
    task automatic test_short_rings();
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
    endtask

    // Full-scale triangles, one in XY and one in YZ
    task automatic test_extreme_coords();
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b1, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
    endtask

    // Tag is taken from the first vertex only; repeated second rings
    task automatic test_tag_on_later_vertices();
        send_vertex(-500, -500, 3, 1'b0, 1'b0);
        send_vertex(500, -500, 1, 1'b1, 1'b0);
        send_vertex(500, 500, -2, 1'b1, 1'b1);
        send_vertex(-400, -400, 0, 1'b1, 1'b0);
        send_vertex(400, -400, 0, 1'b0, 1'b0);
        send_vertex(400, 400, 0, 1'b0, 1'b1);
        send_vertex(-300, 300, 7, 1'b1, 1'b0);
        send_vertex(300, -300, 7, 1'b1, 1'b0);
        send_vertex(300, 300, 7, 1'b1, 1'b1);
    endtask

    // Equal XY and XZ areas: strict comparison gives not axial
    task automatic test_area_tie();
        send_vertex(0, 0, 0, 1'b0, 1'b0);
        send_vertex(100, 0, 0, 1'b0, 1'b0);
        send_vertex(0, 100, 100, 1'b0, 1'b1);
    endtask

    // One vertex over the limit forces not axial; exactly at the limit is fine
    task automatic test_overlong_ring();
        send_planar_ring(MAX_VERTS + 1, rpa_pkg::AXIS_Z, 1'b0, 16, 0.0, 1'b0);
        send_planar_ring(MAX_VERTS, rpa_pkg::AXIS_Z, 1'b1, 16, 0.0, 1'b0);
    endtask

    task automatic test_invalid_axis();
        set_axial_dim(AXIS_NONE);
        send_planar_ring(5, rpa_pkg::AXIS_Z, 1'b0, 12, 0.0, 1'b0);
        send_planar_ring(4, rpa_pkg::AXIS_X, 1'b1, 12, 0.0, 1'b0);
    endtask

    // Long rings that drive the sums into both saturation limits
    task automatic test_sum_saturation();
        set_axial_dim(rpa_pkg::AXIS_Z);
        send_square_loops(68, 0, 1'b0);
        send_square_loops(0, 68, 1'b1);
    endtask

    task automatic send_random_ring(input logic tag);
        int  n;
        real tilt;
        case ($urandom_range(0, 19))
            0:       n = $urandom_range(1, 2);
            1, 2:    n = $urandom_range(MAX_VERTS + 1, MAX_VERTS + 4);
            3:       n = MAX_VERTS;
            default: n = $urandom_range(3, 12);
        endcase
        tilt = ($urandom_range(0, 9) < 3) ? 0.0 : 1.2;
        send_planar_ring(n, 2'($urandom_range(0, 2)), tag, $urandom_range(2, 22),
                         tilt, $urandom_range(0, 6) == 0);
    endtask

    // Mostly well-formed ring pairs, some lone rings and raw noise vertices
    task automatic test_random_rings();
        logic [1:0] axis_order [4];
        int target, next_cfg, phase, idle_off;
        axis_order = '{rpa_pkg::AXIS_X, AXIS_NONE, rpa_pkg::AXIS_Y, rpa_pkg::AXIS_Z};
        target = items_sent + RANDOM_ITEMS;
        idle_off = target - RANDOM_ITEMS / 6;
        next_cfg = items_sent;
        phase = 0;
        while (items_sent < target) begin
            if (items_sent >= next_cfg) begin
                set_axial_dim(phase < 4 ? axis_order[phase] : 2'($urandom_range(0, 3)));
                phase++;
                next_cfg += 250;
            end
            if (items_sent >= idle_off) idle_en = 1'b0;
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6))
                        send_vertex(COORD_W'($urandom), COORD_W'($urandom),
                                    COORD_W'($urandom), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, 3) == 0);
                end
                1: send_random_ring(1'($urandom_range(0, 1)));
                default: begin
                    send_random_ring(1'b0);
                    send_random_ring(1'b1);
                end
            endcase
        end
    endtask

    // ---------------- sequence ----------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_second_before_first();
        test_short_rings();
        test_extreme_coords();
        test_tag_on_later_vertices();
        test_area_tie();
        test_overlong_ring();
        test_invalid_axis();
        test_sum_saturation();
        test_random_rings();
        wait_drained();
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
